/* rtl/gses_pkg.sv */
// shared constants, types and helpers for the grayscale sobel edge stream
package gses_pkg;

  // sizes
  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int PIX_W             = 8;
  localparam int IMAGE_WIDTH_W     = 11;
  localparam int BAND_HEIGHT_W     = 13;
  localparam int ROW_W             = 12;
  localparam int OUT_COL_W         = 10;
  localparam int GRAD_W            = 11;
  localparam int GRAY_SUM_W        = 16;
  localparam int PADDR_W           = 3;
  localparam int PDATA_W           = 32;
  localparam int S_TDATA_W         = 24;
  localparam int M_TDATA_W         = 32;

  // register reset values and limits
  localparam int IMAGE_WIDTH_RESET = 640;
  localparam int BAND_HEIGHT_RESET = 480;
  localparam int BAND_HEIGHT_MAX   = 4096;
  localparam int DIM_MIN           = 3;

  // luma weights and saturation
  localparam int GRAY_B_COEF = 29;
  localparam int GRAY_G_COEF = 150;
  localparam int GRAY_R_COEF = 77;
  localparam int GRAY_SHIFT  = 8;
  localparam int MAG_MAX     = 255;

  // register select (paddr bit 2)
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_BAND_HEIGHT = 1'b1;

  // per-pixel control carried from the front stage to the kernel
  typedef struct packed {
    logic has_result;
    logic last;
  } item_flags_t;

  // absolute value of a gradient
  function automatic logic [GRAD_W-1:0] grad_abs(input logic signed [GRAD_W-1:0] v);
    logic [GRAD_W-1:0] r;
    r = v[GRAD_W-1] ? GRAD_W'(-v) : GRAD_W'(v);
    return r;
  endfunction

endpackage

/* rtl/grayscale_sobel_edge_stream_top.sv */
// top level of the grayscale sobel edge stream
//
// channel   | direction | beat contents
// ----------+-----------+-----------------------------------------------------
// s_*       | in        | tdata: blue, green, red; tuser: band_start
// m_*       | out       | tdata: magnitude, out_column, out_row; tlast: band_last
// apb       | in/out    | image_width at 0x0, band_height at 0x4
//
// one pixel per clock while s_tready is high; a lower-right pixel is registered in
// the front stage and the line store read, then its result in the kernel output register
// reset clears counters, window and output valid; the line stores are not cleared
// s_tready drops only while the kernel stage holds a result and the output
// register is full and not being taken

module grayscale_sobel_edge_stream_top #(
  parameter int MAX_WIDTH = gses_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gses_pkg::S_TDATA_W-1:0]    s_tdata,   // blue, green, red
  input  logic [0:0]                        s_tuser,   // band_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gses_pkg::M_TDATA_W-1:0]    m_tdata,   // magnitude, out_column, out_row, zero pad
  output logic                              m_tlast,   // band_last
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gses_pkg::PADDR_W-1:0]      paddr,
  input  logic [gses_pkg::PDATA_W-1:0]      pwdata,
  output logic [gses_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PW    = gses_pkg::PIX_W;
  localparam int RW    = gses_pkg::ROW_W;
  localparam int IWW   = gses_pkg::IMAGE_WIDTH_W;
  localparam int BHW   = gses_pkg::BAND_HEIGHT_W;
  localparam int W_RESET_CLAMPED = (gses_pkg::IMAGE_WIDTH_RESET > MAX_WIDTH) ?
                                   MAX_WIDTH : gses_pkg::IMAGE_WIDTH_RESET;
  localparam int PAD_W = gses_pkg::M_TDATA_W - PW - gses_pkg::OUT_COL_W - RW;

  logic [IWW-1:0]   image_width;
  logic [BHW-1:0]   band_height;
  logic [COL_W-1:0] wm1, wm1_next;
  logic [RW-1:0]    hm1, hm1_next;
  logic [IWW-1:0]   pw_w;
  logic [BHW-1:0]   pw_h;
  logic             cfg_write;

  logic             accept;
  logic             fire;
  logic             s1_valid;
  logic [COL_W-1:0] rd_addr;
  logic [PW-1:0]    gray;
  logic [COL_W-1:0] col;
  logic [RW-1:0]    row;
  gses_pkg::item_flags_t flags;
  logic [2*PW-1:0]  line_q;

  logic [PW-1:0]                     magnitude;
  logic [gses_pkg::OUT_COL_W-1:0]    out_column;
  logic [RW-1:0]                     out_row;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign pw_w      = pwdata[IWW-1:0];
  assign pw_h      = pwdata[BHW-1:0];

  // clamped row and band end points
  always_comb begin
    if (pw_w < IWW'(gses_pkg::DIM_MIN)) begin
      wm1_next = COL_W'(gses_pkg::DIM_MIN - 1);
    end else if (int'(pw_w) > MAX_WIDTH) begin
      wm1_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1_next = COL_W'(pw_w - IWW'(1));
    end
    if (pw_h < BHW'(gses_pkg::DIM_MIN)) begin
      hm1_next = RW'(gses_pkg::DIM_MIN - 1);
    end else if (pw_h > BHW'(gses_pkg::BAND_HEIGHT_MAX)) begin
      hm1_next = RW'(gses_pkg::BAND_HEIGHT_MAX - 1);
    end else begin
      hm1_next = RW'(pw_h - BHW'(1));
    end
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= IWW'(gses_pkg::IMAGE_WIDTH_RESET);
      band_height <= BHW'(gses_pkg::BAND_HEIGHT_RESET);
      wm1         <= COL_W'(W_RESET_CLAMPED - 1);
      hm1         <= RW'(gses_pkg::BAND_HEIGHT_RESET - 1);
    end else if (cfg_write) begin
      case (paddr[2])
        gses_pkg::REG_IMAGE_WIDTH: begin
          image_width <= pw_w;
          wm1         <= wm1_next;
        end
        gses_pkg::REG_BAND_HEIGHT: begin
          band_height <= pw_h;
          hm1         <= hm1_next;
        end
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[2])
      gses_pkg::REG_IMAGE_WIDTH: prdata = gses_pkg::PDATA_W'(image_width);
      gses_pkg::REG_BAND_HEIGHT: prdata = gses_pkg::PDATA_W'(band_height);
      default:                   prdata = '0;
    endcase
  end

  // pipeline handshake
  assign fire     = s1_valid && (!flags.has_result || !m_tvalid || m_tready);
  assign s_tready = !s1_valid || fire;
  assign accept   = s_tvalid && s_tready;

  gses_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .fire       (fire),
    .blue       (s_tdata[PW-1:0]),
    .green      (s_tdata[2*PW-1:PW]),
    .red        (s_tdata[3*PW-1:2*PW]),
    .band_start (s_tuser[0]),
    .wm1        (wm1),
    .hm1        (hm1),
    .rd_addr    (rd_addr),
    .s1_valid   (s1_valid),
    .gray       (gray),
    .col        (col),
    .row        (row),
    .flags      (flags)
  );

  // line store: older row above newer row, written back as the pixel retires
  gses_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr_en   (fire),
    .wr_addr (col),
    .wr_data ({line_q[PW-1:0], gray}),
    .rd_data (line_q)
  );

  gses_kernel #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_kernel (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .gray       (gray),
    .col        (col),
    .row        (row),
    .flags      (flags),
    .line_q     (line_q),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .magnitude  (magnitude),
    .out_column (out_column),
    .out_row    (out_row),
    .band_last  (m_tlast)
  );

  // output beat packing
  assign m_tdata = {{PAD_W{1'b0}}, out_row, out_column, magnitude};

endmodule

/* rtl/gses_front.sv */
// front stage: gray conversion, raster counters and border flags
module gses_front #(
  parameter int MAX_WIDTH = gses_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic                              fire,
  input  logic [gses_pkg::PIX_W-1:0]        blue,
  input  logic [gses_pkg::PIX_W-1:0]        green,
  input  logic [gses_pkg::PIX_W-1:0]        red,
  input  logic                              band_start,
  input  logic [$clog2(MAX_WIDTH)-1:0]      wm1,
  input  logic [gses_pkg::ROW_W-1:0]        hm1,
  output logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
  output logic                              s1_valid,
  output logic [gses_pkg::PIX_W-1:0]        gray,
  output logic [$clog2(MAX_WIDTH)-1:0]      col,
  output logic [gses_pkg::ROW_W-1:0]        row,
  output gses_pkg::item_flags_t             flags
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [COL_W-1:0]                   column_count;
  logic [gses_pkg::ROW_W-1:0]         row_count;
  logic [COL_W-1:0]                   col_eff;
  logic [gses_pkg::ROW_W-1:0]         row_eff;
  logic [COL_W-1:0]                   column_count_next;
  logic [gses_pkg::ROW_W-1:0]         row_count_next;
  logic [gses_pkg::GRAY_SUM_W-1:0]    gray_sum;
  gses_pkg::item_flags_t              flags_next;

  // position of this pixel, band start restarts the raster
  always_comb begin
    col_eff = band_start ? '0 : column_count;
    row_eff = band_start ? '0 : row_count;
    rd_addr = col_eff;
  end

  // weighted luma sum
  always_comb begin
    gray_sum = gses_pkg::GRAY_SUM_W'(gses_pkg::GRAY_B_COEF) * gses_pkg::GRAY_SUM_W'(blue)
             + gses_pkg::GRAY_SUM_W'(gses_pkg::GRAY_G_COEF) * gses_pkg::GRAY_SUM_W'(green)
             + gses_pkg::GRAY_SUM_W'(gses_pkg::GRAY_R_COEF) * gses_pkg::GRAY_SUM_W'(red);
  end

  // interior test, band end and counter advance
  always_comb begin
    flags_next.has_result = (row_eff >= gses_pkg::ROW_W'(2)) && (row_eff <= hm1)
                          && (col_eff >= COL_W'(2));
    flags_next.last       = (row_eff == hm1) && (col_eff == wm1);
    if (col_eff >= wm1) begin
      column_count_next = '0;
      row_count_next    = (row_eff >= hm1) ? '0 : row_eff + gses_pkg::ROW_W'(1);
    end else begin
      column_count_next = col_eff + COL_W'(1);
      row_count_next    = row_eff;
    end
  end

  // counters and stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      s1_valid     <= 1'b1;
    end else if (fire) begin
      s1_valid     <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      gray  <= gray_sum[gses_pkg::GRAY_SHIFT +: gses_pkg::PIX_W];
      col   <= col_eff;
      row   <= row_eff;
      flags <= flags_next;
    end
  end

endmodule

/* rtl/gses_line_mem.sv */
// line store memory holding the two previous rows, with same-entry bypass
module gses_line_mem #(
  parameter int DEPTH  = gses_pkg::MAX_WIDTH_DEFAULT,
  parameter int DATA_W = 2 * gses_pkg::PIX_W
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [DATA_W-1:0]         wr_data,
  output logic [DATA_W-1:0]         rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;
  logic [DATA_W-1:0] bypass_data;
  logic              bypass;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, catching a write to the same entry in the same cycle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q       <= mem[rd_addr];
      bypass      <= wr_en && (wr_addr == rd_addr);
      bypass_data <= wr_data;
    end
  end

  assign rd_data = bypass ? bypass_data : mem_q;

endmodule

/* rtl/gses_kernel.sv */
// 3x3 window, sobel magnitude and output register
module gses_kernel #(
  parameter int MAX_WIDTH = gses_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  logic [gses_pkg::PIX_W-1:0]        gray,
  input  logic [$clog2(MAX_WIDTH)-1:0]      col,
  input  logic [gses_pkg::ROW_W-1:0]        row,
  input  gses_pkg::item_flags_t             flags,
  input  logic [2*gses_pkg::PIX_W-1:0]      line_q,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [gses_pkg::PIX_W-1:0]        magnitude,
  output logic [gses_pkg::OUT_COL_W-1:0]    out_column,
  output logic [gses_pkg::ROW_W-1:0]        out_row,
  output logic                              band_last
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int PW    = gses_pkg::PIX_W;
  localparam int GW    = gses_pkg::GRAD_W;

  // window columns c-1 and c-2: top, middle, bottom
  logic [PW-1:0] w1_t, w1_m, w1_b;
  logic [PW-1:0] w2_t, w2_m, w2_b;

  logic [PW-1:0]        tr, mr;
  logic signed [GW-1:0] e_tl, e_ml, e_bl, e_tm, e_bm, e_tr, e_mr, e_br;
  logic signed [GW-1:0] gx, gy;
  logic [GW-1:0]        mag_sum;
  logic [PW-1:0]        mag_sat;
  logic [COL_W-1:0]     cm1;

  assign tr = line_q[2*PW-1:PW];
  assign mr = line_q[PW-1:0];

  // gradients from the window and the incoming column
  always_comb begin
    e_tl = GW'(signed'({1'b0, w2_t}));
    e_ml = GW'(signed'({1'b0, w2_m}));
    e_bl = GW'(signed'({1'b0, w2_b}));
    e_tm = GW'(signed'({1'b0, w1_t}));
    e_bm = GW'(signed'({1'b0, w1_b}));
    e_tr = GW'(signed'({1'b0, tr}));
    e_mr = GW'(signed'({1'b0, mr}));
    e_br = GW'(signed'({1'b0, gray}));
    gx = (e_tr - e_tl) + ((e_mr - e_ml) <<< 1) + (e_br - e_bl);
    gy = (e_bl - e_tl) + ((e_bm - e_tm) <<< 1) + (e_br - e_tr);
    mag_sum = gses_pkg::grad_abs(gx) + gses_pkg::grad_abs(gy);
    mag_sat = (mag_sum > GW'(gses_pkg::MAG_MAX)) ? PW'(gses_pkg::MAG_MAX) : mag_sum[PW-1:0];
    cm1 = col - COL_W'(1);
  end

  // window shift and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      w1_t     <= '0;
      w1_m     <= '0;
      w1_b     <= '0;
      w2_t     <= '0;
      w2_m     <= '0;
      w2_b     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        w2_t <= w1_t;
        w2_m <= w1_m;
        w2_b <= w1_b;
        w1_t <= tr;
        w1_m <= mr;
        w1_b <= gray;
      end
      if (fire && flags.has_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (fire && flags.has_result) begin
      magnitude  <= mag_sat;
      out_column <= gses_pkg::OUT_COL_W'(cm1);
      out_row    <= row - gses_pkg::ROW_W'(1);
      band_last  <= flags.last;
    end
  end

endmodule

/* rtl/gses_checker.sv */
// port-level checks for the grayscale sobel edge stream, bound to the top level
module gses_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gses_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tlast,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic                           pready,
  input logic [gses_pkg::PADDR_W-1:0]   paddr,
  input logic [gses_pkg::PDATA_W-1:0]   pwdata,
  input logic [gses_pkg::PDATA_W-1:0]   prdata
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // results are interior: centre row never zero, pad bits clear
  a_out_interior: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[29:18] != 12'd0) && (m_tdata[31:30] == 2'b00))
    else $error("result outside the band interior");

  // no result straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // image width reads back what was written
  a_width_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[2]
    |=> !(psel && !pwrite && !paddr[2])
        || ((prdata[10:0] == $past(pwdata[10:0])) && (prdata[31:11] == 21'd0)))
    else $error("image width readback mismatch");

endmodule

bind grayscale_sobel_edge_stream_top gses_checker u_gses_checker (.*);

/* sim/grayscale_sobel_edge_stream_top_test.sv */
// self-checking testbench for the grayscale sobel edge stream top level
module grayscale_sobel_edge_stream_top_test;
  import gses_pkg::*;

  localparam int MAX_W       = MAX_WIDTH_DEFAULT;
  localparam int SETTLE      = 8;
  localparam int QUIET_LIMIT = 1000;

  typedef struct packed {
    bit [PIX_W-1:0] blue;
    bit [PIX_W-1:0] green;
    bit [PIX_W-1:0] red;
    bit             band_start;
  } pixel_t;

  typedef struct packed {
    bit [PIX_W-1:0]     magnitude;
    bit [OUT_COL_W-1:0] column;
    bit [ROW_W-1:0]     row;
    bit                 last;
  } edge_result_t;

  // gray conversion, line stores, 3x3 window and pending edge results
  class edge_scoreboard;
    bit [IMAGE_WIDTH_W-1:0] width_reg;
    bit [BAND_HEIGHT_W-1:0] height_reg;
    bit [PIX_W-1:0]         older_line [MAX_W];
    bit [PIX_W-1:0]         newer_line [MAX_W];
    // gray columns c-1 (near) and c-2 (far)
    int                     near_top, near_mid, near_bot;
    int                     far_top, far_mid, far_bot;
    int unsigned            col_count, row_count;
    edge_result_t           pending_edges[$];
    int unsigned            fail_count;

    function new();
      width_reg  = IMAGE_WIDTH_W'(IMAGE_WIDTH_RESET);
      height_reg = BAND_HEIGHT_W'(BAND_HEIGHT_RESET);
    endfunction

    function void set_register(logic sel, int unsigned value);
      if (sel == REG_IMAGE_WIDTH) begin
        width_reg = value[IMAGE_WIDTH_W-1:0];
      end else begin
        height_reg = value[BAND_HEIGHT_W-1:0];
      end
    endfunction

    function int unsigned used_width();
      if (width_reg < DIM_MIN) return DIM_MIN;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned used_height();
      if (height_reg < DIM_MIN) return DIM_MIN;
      if (height_reg > BAND_HEIGHT_MAX) return BAND_HEIGHT_MAX;
      return height_reg;
    endfunction

    function void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    // accepted pixel: update window and line stores, queue any edge result
    function void note_pixel(pixel_t px);
      int unsigned  w, h, gray, c, r, idx;
      int           tr, mr, br, gx, gy, mag;
      edge_result_t res;
      w = used_width();
      h = used_height();
      gray = (GRAY_B_COEF * px.blue + GRAY_G_COEF * px.green + GRAY_R_COEF * px.red)
             >> GRAY_SHIFT;
      if (px.band_start) begin
        col_count = 0;
        row_count = 0;
      end
      c   = col_count;
      r   = row_count;
      idx = c % MAX_W;
      tr  = older_line[idx];
      mr  = newer_line[idx];
      br  = gray;
      // interior centre pixel once its lower-right neighbour is here
      if (r >= 2 && r <= h - 1 && c >= 2) begin
        gx  = (tr - far_top) + 2 * (mr - far_mid) + (br - far_bot);
        gy  = (far_bot - far_top) + 2 * (near_bot - near_top) + (br - tr);
        mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
        if (mag > MAG_MAX) mag = MAG_MAX;
        res.magnitude = PIX_W'(mag);
        res.column    = OUT_COL_W'(c - 1);
        res.row       = ROW_W'(r - 1);
        res.last      = (r == h - 1) && (c == w - 1);
        pending_edges.push_back(res);
      end
      far_top  = near_top;
      far_mid  = near_mid;
      far_bot  = near_bot;
      near_top = tr;
      near_mid = mr;
      near_bot = br;
      older_line[idx] = PIX_W'(mr);
      newer_line[idx] = PIX_W'(gray);
      // raster position of the next pixel
      if (c >= w - 1) begin
        col_count = 0;
        row_count = (r >= h - 1) ? 0 : r + 1;
      end else begin
        col_count = c + 1;
      end
    endfunction

    function void check_result(edge_result_t got);
      edge_result_t want;
      if (pending_edges.size() == 0) begin
        note_failure($sformatf("unexpected beat: mag %0d col %0d row %0d last %0b",
                               got.magnitude, got.column, got.row, got.last));
        return;
      end
      want = pending_edges.pop_front();
      if (got != want) begin
        note_failure($sformatf(
          "edge result differs: expected mag %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
          want.magnitude, want.column, want.row, want.last,
          got.magnitude, got.column, got.row, got.last));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // blue, green, red
  logic [0:0]           s_tuser  = '0;   // band_start
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;         // magnitude, out_column, out_row, zero pad
  logic                 m_tlast;         // band_last
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [PDATA_W-1:0]   pwdata   = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  edge_scoreboard sb = new();
  int unsigned    send_idle_pct  = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    phase_count    = 0;
  int unsigned    sent_pixels    = 0;
  int unsigned    quiet_cycles   = 0;

  grayscale_sobel_edge_stream_top #(
    .MAX_WIDTH(MAX_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // result beats against the predicted edges
  always @(posedge clk) begin
    edge_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.magnitude = m_tdata[PIX_W-1:0];
      got.column    = m_tdata[PIX_W +: OUT_COL_W];
      got.row       = m_tdata[PIX_W + OUT_COL_W +: ROW_W];
      got.last      = m_tlast;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
          (psel && penable && pwrite && pready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic pixel_t make_pixel(int unsigned b, int unsigned g, int unsigned r,
                                        bit start);
    pixel_t px;
    px.blue       = PIX_W'(b);
    px.green      = PIX_W'(g);
    px.red        = PIX_W'(r);
    px.band_start = start;
    return px;
  endfunction

  // colour byte biased towards the extremes
  function automatic int unsigned colour_byte();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return 0;
    if (pick == 1) return 255;
    return $urandom_range(255);
  endfunction

  function automatic void set_idle_mode(int unsigned mode);
    case (mode % 4)
      0: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct  = 50;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct  = 0;
        recv_stall_pct = 50;
      end
      default: begin
        send_idle_pct  = 19;
        recv_stall_pct = 19;
      end
    endcase
  endfunction

  // one pixel beat, with random idle cycles in front
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {px.red, px.green, px.blue};
    s_tuser  <= px.band_start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(px);
    sent_pixels++;
  endtask

  // setup phase, then access phase, then the bus is released
  task automatic write_reg(input logic sel, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(sel, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // all predicted edges out, then a settle wait for work that gives no result
  task automatic wait_idle();
    while (sb.pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // new register setting, then a run of random pixels
  // a negative count asks for one or two bands plus a partial row
  task automatic run_phase(input int unsigned width_val, input int unsigned height_val,
                           input int count, input bit restart);
    int unsigned old_width;
    pixel_t      px;
    wait_idle();
    set_idle_mode(phase_count);
    phase_count++;
    old_width = sb.used_width();
    write_reg(REG_IMAGE_WIDTH, width_val);
    write_reg(REG_BAND_HEIGHT, height_val);
    // a wider row must not reach line entries never written
    if (sb.used_width() > old_width) restart = 1'b1;
    if (count < 0) begin
      count = sb.used_width() * sb.used_height() * $urandom_range(1, 2) +
              $urandom_range(0, sb.used_width());
    end
    for (int i = 0; i < count; i++) begin
      px = make_pixel(colour_byte(), colour_byte(), colour_byte(), 1'b0);
      px.band_start = (i == 0 && restart) || ($urandom_range(199) == 0);
      send_pixel(px);
    end
    s_tvalid <= 1'b0;
  endtask

  // stimulus
  initial begin
    int unsigned target;
    int unsigned w_raw, h_raw;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers below range: both used as three
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_BAND_HEIGHT, 1);

    // black, mid grey and white columns: saturated gradient
    for (int k = 0; k < 9; k++) begin
      case (k % 3)
        0:       send_pixel(make_pixel(0, 0, 0, k == 0));
        1:       send_pixel(make_pixel(128, 128, 128, 1'b0));
        default: send_pixel(make_pixel(255, 255, 255, 1'b0));
      endcase
    end
    // counters wrap into a second band: single-channel extremes
    for (int k = 0; k < 9; k++) begin
      case ((k + k / 3) % 3)
        0:       send_pixel(make_pixel(255, 0, 0, 1'b0));
        1:       send_pixel(make_pixel(0, 255, 0, 1'b0));
        default: send_pixel(make_pixel(0, 0, 255, 1'b0));
      endcase
    end
    // band start in the middle of a row, flat rows give zero magnitude
    send_pixel(make_pixel(255, 255, 255, 1'b0));
    for (int k = 0; k < 9; k++) begin
      if (k / 3 == 1) begin
        send_pixel(make_pixel(255, 255, 255, k == 0));
      end else begin
        send_pixel(make_pixel(0, 0, 0, k == 0));
      end
    end
    s_tvalid <= 1'b0;

    // fixed settings: height cut and width cut in mid band, both maxima
    run_phase(5, 4, 60, 1'b1);
    run_phase(6, 6, 30, 1'b1);
    run_phase(6, 2, 40, 1'b0);
    run_phase(8, 5, 20, 1'b1);
    run_phase(4, 5, 40, 1'b0);
    run_phase(4, 8191, 60, 1'b1);
    run_phase(2047, 3, 20, 1'b1);

    // random small images
    target = sent_pixels + 230;
    while (sent_pixels < target) begin
      w_raw = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h_raw = ($urandom_range(9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      run_phase(w_raw, h_raw, -1, $urandom_range(3) != 0);
    end

    wait_idle();
    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* grayscale_sobel_edge_stream_top.f */
rtl/gses_pkg.sv
rtl/gses_front.sv
rtl/gses_line_mem.sv
rtl/gses_kernel.sv
rtl/grayscale_sobel_edge_stream_top.sv
rtl/gses_checker.sv
sim/grayscale_sobel_edge_stream_top_test.sv
